>>> rtl/core/bth_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// Shared constants, widths and stage types of the BGR to HSV pixel pipeline.
// ----------------------------------------------------------------------------
package bth_pkg;

  localparam int CH_W       = 8;
  localparam int Q_W        = 8;
  localparam int FULL_SCALE = 255;
  localparam int TURN_DEG   = 360;
  localparam int SECTOR_DEG = 60;
  localparam int GREEN_BASE = 120;
  localparam int BLUE_BASE  = 240;
  localparam int DIV_STEPS  = Q_W;

  // hue dividend: angle numerator (< 360*255) times 255
  localparam int HUE_REM_W = 25;
  // saturation dividend: chroma times 255
  localparam int SAT_REM_W = 16;

  typedef logic [CH_W-1:0]      chan_t;
  typedef logic [Q_W-1:0]       quot_t;
  typedef logic [HUE_REM_W-1:0] hue_rem_t;
  typedef logic [SAT_REM_W-1:0] sat_rem_t;

  // payload of one divide stage: both quotient lanes plus brightness
  typedef struct packed {
    hue_rem_t hue_rem;
    hue_rem_t hue_dsh;
    quot_t    hue_q;
    sat_rem_t sat_rem;
    sat_rem_t sat_dsh;
    quot_t    sat_q;
    chan_t    bright;
  } div_stage_t;

endpackage

>>> rtl/core/bgr_to_hsv_pixel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_hsv_pixel
// 8-bit BGR pixel to 8-bit hue, saturation and brightness, exact quotients.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output side does not stall and returns
// one result per pixel, in order. Three front stages find max/min, the hue
// sector and the scaled dividends; eight restoring divide stages then
// produce one quotient bit each for hue and saturation in parallel, the last
// one doubling as the output register.
// The whole pipe advances together: in_ready is low only while a result
// waits at the output and out_ready is low.
// ----------------------------------------------------------------------------
module bgr_to_hsv_pixel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_hue,
  output logic [7:0]            out_saturation,
  output logic [7:0]            out_brightness
);

  logic                 en;
  logic                 vld [bth_pkg::DIV_STEPS+1];
  bth_pkg::div_stage_t  data [bth_pkg::DIV_STEPS+1];

  // advance when the output slot is empty or being drained
  assign en       = !vld[bth_pkg::DIV_STEPS] || out_ready;
  assign in_ready = en;

  bth_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_blue   (in_blue),
    .in_green  (in_green),
    .in_red    (in_red),
    .out_valid (vld[0]),
    .out_data  (data[0])
  );

  for (genvar i = 0; i < bth_pkg::DIV_STEPS; i++) begin : g_div
    bth_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (vld[i]),
      .in_data   (data[i]),
      .out_valid (vld[i+1]),
      .out_data  (data[i+1])
    );
  end

  assign out_valid      = vld[bth_pkg::DIV_STEPS];
  assign out_hue        = data[bth_pkg::DIV_STEPS].hue_q;
  assign out_saturation = data[bth_pkg::DIV_STEPS].sat_q;
  assign out_brightness = data[bth_pkg::DIV_STEPS].bright;

  a_black_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == 8'd0) |-> out_saturation == 8'd0)
    else $error("black pixel with nonzero saturation");

  a_gray_no_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == 8'd0) |-> out_hue == 8'd0)
    else $error("gray pixel with nonzero hue");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue != 8'd255)
    else $error("hue reached a full turn");

endmodule

>>> rtl/core/bth_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_front
// First three pipeline stages: max/min and sector, angle numerator and
// divisors, then scaled dividends and pre-shifted divisors for the dividers.
// ----------------------------------------------------------------------------
module bth_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  bth_pkg::chan_t       in_blue,
  input  bth_pkg::chan_t       in_green,
  input  bth_pkg::chan_t       in_red,
  output logic                 out_valid,
  output bth_pkg::div_stage_t  out_data
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // stage 1
  logic                  vld1_r;
  bth_pkg::chan_t        hi1_r, hi1_nxt;
  bth_pkg::chan_t        chroma1_r, chroma1_nxt;
  sector_t               sector1_r, sector1_nxt;
  logic signed [8:0]     diff1_r, diff1_nxt;
  bth_pkg::chan_t        lo_c;

  // stage 2
  logic                  vld2_r;
  logic [16:0]           num2_r, num2_nxt;
  logic [16:0]           hue_div2_r, hue_div2_nxt;
  bth_pkg::sat_rem_t     sat_dvd2_r, sat_dvd2_nxt;
  bth_pkg::chan_t        sat_div2_r, sat_div2_nxt;
  bth_pkg::chan_t        bright2_r;
  logic signed [18:0]    c_s, d_s, num_s;

  // stage 3
  logic                  vld3_r;
  bth_pkg::div_stage_t   data3_r, data3_nxt;

  always_comb begin
    hi1_nxt = in_red;
    lo_c    = in_red;
    if (in_green > hi1_nxt) hi1_nxt = in_green;
    if (in_blue > hi1_nxt)  hi1_nxt = in_blue;
    if (in_green < lo_c)    lo_c = in_green;
    if (in_blue < lo_c)     lo_c = in_blue;
    chroma1_nxt = hi1_nxt - lo_c;
    // ties go blue, then green, then red
    if (in_blue == hi1_nxt) begin
      sector1_nxt = SEC_BLUE;
      diff1_nxt   = $signed({1'b0, in_red}) - $signed({1'b0, in_green});
    end else if (in_green == hi1_nxt) begin
      sector1_nxt = SEC_GREEN;
      diff1_nxt   = $signed({1'b0, in_blue}) - $signed({1'b0, in_red});
    end else begin
      sector1_nxt = SEC_RED;
      diff1_nxt   = $signed({1'b0, in_green}) - $signed({1'b0, in_blue});
    end
  end

  always_comb begin
    c_s = $signed({11'd0, chroma1_r});
    d_s = 19'(diff1_r);
    case (sector1_r)
      SEC_BLUE:  num_s = 19'(bth_pkg::BLUE_BASE) * c_s + 19'(bth_pkg::SECTOR_DEG) * d_s;
      SEC_GREEN: num_s = 19'(bth_pkg::GREEN_BASE) * c_s + 19'(bth_pkg::SECTOR_DEG) * d_s;
      default:   num_s = 19'(bth_pkg::SECTOR_DEG) * d_s;
    endcase
    if (num_s < 0) num_s = num_s + 19'(bth_pkg::TURN_DEG) * c_s;
    // gray pixel: zero numerator over a nonzero divisor gives hue 0
    if (chroma1_r == '0) begin
      num2_nxt     = '0;
      hue_div2_nxt = 17'(bth_pkg::TURN_DEG);
    end else begin
      num2_nxt     = num_s[16:0];
      hue_div2_nxt = 17'(bth_pkg::TURN_DEG) * {9'd0, chroma1_r};
    end
    sat_dvd2_nxt = bth_pkg::sat_rem_t'(chroma1_r) * bth_pkg::sat_rem_t'(bth_pkg::FULL_SCALE);
    // black pixel: keep the divisor nonzero, the dividend is zero anyway
    sat_div2_nxt = (hi1_r == '0) ? bth_pkg::chan_t'(1) : hi1_r;
  end

  always_comb begin
    data3_nxt.hue_rem = bth_pkg::hue_rem_t'(num2_r) *
                        bth_pkg::hue_rem_t'(bth_pkg::FULL_SCALE);
    data3_nxt.hue_dsh = bth_pkg::hue_rem_t'({hue_div2_r, {(bth_pkg::Q_W-1){1'b0}}});
    data3_nxt.hue_q   = '0;
    data3_nxt.sat_rem = sat_dvd2_r;
    data3_nxt.sat_dsh = bth_pkg::sat_rem_t'({sat_div2_r, {(bth_pkg::Q_W-1){1'b0}}});
    data3_nxt.sat_q   = '0;
    data3_nxt.bright  = bright2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_valid;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi1_r      <= hi1_nxt;
      chroma1_r  <= chroma1_nxt;
      sector1_r  <= sector1_nxt;
      diff1_r    <= diff1_nxt;
      num2_r     <= num2_nxt;
      hue_div2_r <= hue_div2_nxt;
      sat_dvd2_r <= sat_dvd2_nxt;
      sat_div2_r <= sat_div2_nxt;
      bright2_r  <= hi1_r;
      data3_r    <= data3_nxt;
    end
  end

  assign out_valid = vld3_r;
  assign out_data  = data3_r;

endmodule

>>> rtl/core/bth_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_div_stage
// One restoring divide step for the hue and saturation lanes, registered.
// The divisor arrives pre-shifted and moves one bit right per stage.
// ----------------------------------------------------------------------------
module bth_div_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  bth_pkg::div_stage_t  in_data,
  output logic                 out_valid,
  output bth_pkg::div_stage_t  out_data
);

  logic                 vld_r;
  bth_pkg::div_stage_t  data_r, data_nxt;
  logic                 hue_take, sat_take;

  always_comb begin
    hue_take = (in_data.hue_rem >= in_data.hue_dsh);
    sat_take = (in_data.sat_rem >= in_data.sat_dsh);
    data_nxt.hue_rem = hue_take ? in_data.hue_rem - in_data.hue_dsh : in_data.hue_rem;
    data_nxt.hue_dsh = in_data.hue_dsh >> 1;
    data_nxt.hue_q   = {in_data.hue_q[bth_pkg::Q_W-2:0], hue_take};
    data_nxt.sat_rem = sat_take ? in_data.sat_rem - in_data.sat_dsh : in_data.sat_rem;
    data_nxt.sat_dsh = in_data.sat_dsh >> 1;
    data_nxt.sat_q   = {in_data.sat_q[bth_pkg::Q_W-2:0], sat_take};
    data_nxt.bright  = in_data.bright;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

>>> sim/hsv_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_result_checker
// Watches both channels of the BGR to HSV converter and checks each result.
// Every accepted pixel gets its hue, saturation and brightness worked out
// with exact integer math. The expected triple is queued, and each accepted
// result is compared field by field with the oldest queued triple.
// ----------------------------------------------------------------------------
module hsv_result_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  bth_pkg::chan_t in_blue,
  input  bth_pkg::chan_t in_green,
  input  bth_pkg::chan_t in_red,
  input  logic           out_valid,
  input  logic           out_ready,
  input  bth_pkg::chan_t out_hue,
  input  bth_pkg::chan_t out_saturation,
  input  bth_pkg::chan_t out_brightness,
  output int             n_fail,
  output int             n_pending,
  output int             n_checked
);

  typedef struct packed {
    bth_pkg::chan_t hue;
    bth_pkg::chan_t sat;
    bth_pkg::chan_t bright;
  } hsv_t;

  hsv_t expected_hsv_q[$];
  int   fail_cnt     = 0;
  int   checked_cnt  = 0;
  int   fail_seen    = 0;
  int   pending_seen = 0;
  int   checked_seen = 0;

  assign n_fail    = fail_seen;
  assign n_pending = pending_seen;
  assign n_checked = checked_seen;

  function automatic hsv_t convert_pixel(bth_pkg::chan_t b, bth_pkg::chan_t g,
                                         bth_pkg::chan_t r);
    int   bi, gi, ri, hi, lo, chroma, angle_num;
    hsv_t res;
    bi = b;
    gi = g;
    ri = r;
    hi = ri;
    lo = ri;
    if (gi > hi) hi = gi;
    if (bi > hi) hi = bi;
    if (gi < lo) lo = gi;
    if (bi < lo) lo = bi;
    chroma = hi - lo;
    res.bright = bth_pkg::chan_t'(hi);
    if (hi == 0)
      res.sat = '0;
    else
      res.sat = bth_pkg::chan_t'((chroma * bth_pkg::FULL_SCALE) / hi);
    if (chroma == 0) begin
      res.hue = '0;
    end else begin
      // blue wins ties over green, green over red
      if (hi == bi)
        angle_num = bth_pkg::BLUE_BASE * chroma + bth_pkg::SECTOR_DEG * (ri - gi);
      else if (hi == gi)
        angle_num = bth_pkg::GREEN_BASE * chroma + bth_pkg::SECTOR_DEG * (bi - ri);
      else
        angle_num = bth_pkg::SECTOR_DEG * (gi - bi);
      // wrap into one turn, angle is angle_num / chroma degrees
      if (angle_num < 0) angle_num += bth_pkg::TURN_DEG * chroma;
      res.hue = bth_pkg::chan_t'((angle_num * bth_pkg::FULL_SCALE) /
                                 (bth_pkg::TURN_DEG * chroma));
    end
    return res;
  endfunction

  always @(posedge clk) begin
    hsv_t want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_hsv_q = {expected_hsv_q, convert_pixel(in_blue, in_green, in_red)};
      if (out_valid && out_ready) begin
        if (expected_hsv_q.size() == 0) begin
          $error("unexpected result: hue %0d saturation %0d brightness %0d",
                 out_hue, out_saturation, out_brightness);
          fail_cnt++;
        end else begin
          want = expected_hsv_q.pop_front();
          checked_cnt++;
          if (out_hue !== want.hue) begin
            $error("hue mismatch: expected %0d, actual %0d", want.hue, out_hue);
            fail_cnt++;
          end
          if (out_saturation !== want.sat) begin
            $error("saturation mismatch: expected %0d, actual %0d",
                   want.sat, out_saturation);
            fail_cnt++;
          end
          if (out_brightness !== want.bright) begin
            $error("brightness mismatch: expected %0d, actual %0d",
                   want.bright, out_brightness);
            fail_cnt++;
          end
        end
      end
    end
    fail_seen    <= fail_cnt;
    pending_seen <= expected_hsv_q.size();
    checked_seen <= checked_cnt;
  end

endmodule

>>> sim/bgr_to_hsv_pixel_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgr_to_hsv_pixel_tb
// Stimulus and verdict for the BGR to HSV pixel converter.
// Directed corner pixels come first: black, white, gray, pure colors, tied
// maxima and wrapping hues. Random pixels follow under four traffic mixes,
// including one long output hold-off and five full drain pauses.
// hsv_result_checker does all of the result checking.
// ----------------------------------------------------------------------------
module bgr_to_hsv_pixel_tb;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 100;
  localparam int TAIL_CYCLES  = 24;
  localparam int PHASE_PIXELS = 330;
  localparam int N_CORNERS    = 22;

  logic           clk            = 1'b0;
  logic           rst_n          = 1'b0;
  logic           in_valid       = 1'b0;
  logic           in_ready;
  bth_pkg::chan_t in_blue        = '0;
  bth_pkg::chan_t in_green       = '0;
  bth_pkg::chan_t in_red         = '0;
  logic           out_valid;
  logic           out_ready      = 1'b0;
  bth_pkg::chan_t out_hue;
  bth_pkg::chan_t out_saturation;
  bth_pkg::chan_t out_brightness;

  int n_fail;
  int n_pending;
  int n_checked;

  int idle_pct  = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  // corner pixels packed as {blue, green, red}
  logic [23:0] corner_px [N_CORNERS] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'h0000FF, 24'h00FF00,
    24'hFF0000, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0100FF, 24'h0001FF,
    24'h000001, 24'h010100, 24'hFEFF00, 24'h00FEFF, 24'hFFFE00, 24'hAA5501,
    24'h55AAFF, 24'h646463, 24'hFF0001, 24'hFE01FF
  };

  bgr_to_hsv_pixel uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  hsv_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness),
    .n_fail         (n_fail),
    .n_pending      (n_pending),
    .n_checked      (n_checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // output side: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Run exceeded %0d cycles with %0d results outstanding",
               CYCLE_LIMIT, n_pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(input bth_pkg::chan_t b, input bth_pkg::chan_t g,
                            input bth_pkg::chan_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_blue  <= b;
    in_green <= g;
    in_red   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_random(input int count);
    int             kind;
    bth_pkg::chan_t v, b, g, r;
    repeat (count) begin
      kind = $urandom_range(9);
      v = bth_pkg::chan_t'($urandom);
      b = bth_pkg::chan_t'($urandom);
      g = bth_pkg::chan_t'($urandom);
      r = bth_pkg::chan_t'($urandom);
      case (kind)
        0: begin
          b = v;
          g = v;
          r = v;
        end
        1: begin
          b = v;
          g = v;
          r = bth_pkg::chan_t'($urandom_range(v));
        end
        2: begin
          g = v;
          r = v;
          b = bth_pkg::chan_t'($urandom_range(v));
        end
        3: begin
          b = v;
          r = v;
          g = bth_pkg::chan_t'($urandom_range(v));
        end
        4: begin
          b = bth_pkg::chan_t'($urandom_range(3));
          g = bth_pkg::chan_t'($urandom_range(3));
          r = bth_pkg::chan_t'($urandom_range(3));
        end
        5: begin
          b = bth_pkg::chan_t'($urandom_range(255, 240));
          g = bth_pkg::chan_t'($urandom_range(255, 240));
          r = bth_pkg::chan_t'($urandom_range(255, 240));
        end
        default: ;
      endcase
      send_pixel(b, g, r);
    end
  endtask

  // drop valid and hold until every queued result is out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_px[i])
      send_pixel(corner_px[i][23:16], corner_px[i][15:8], corner_px[i][7:0]);

    // back-to-back traffic, then stall the output to fill the pipe
    run_random(40);
    hold_req <= hold_req + 1;
    run_random(60);
    wait_drain();
    run_random(PHASE_PIXELS - 100);
    wait_drain();

    idle_pct = 70;
    run_random(PHASE_PIXELS);
    wait_drain();

    idle_pct = 0;
    stall_pct <= 70;
    run_random(PHASE_PIXELS);
    wait_drain();

    idle_pct = 36;
    stall_pct <= 36;
    run_random(PHASE_PIXELS);
    wait_drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
    $display("Checked %0d results: %0d corner pixels and four random traffic mixes",
             n_checked, N_CORNERS);
    $display("Covered a %0d-cycle output hold-off with input backpressure and a drain pause",
             HOLD_CYCLES);
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
